### src/mtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared types, opcodes, status codes and helpers of the memory-to-memory
// instruction executor.
// ----------------------------------------------------------------------------
package mtm_pkg;

   // Default sizes of the data memory.
   localparam int MEM_DEPTH_DEF   = 1024;
   localparam int WORD_BITS_DEF   = 64;

   // Fixed field widths of the item channels.
   localparam int FUNC_BITS       = 4;
   localparam int ADDR_FIELD_BITS = 10;
   localparam int IMM_BITS        = 32;
   localparam int PC_OUT_BITS     = 11;
   localparam int STATUS_BITS     = 2;
   localparam int VALUE_OUT_BITS  = 64;

   // Widest word address the design supports (65536 words).
   localparam int ADDR_MAX_BITS   = 16;

   // A positive result at or above 2**OVF_BIT exceeds the largest 32-bit integer.
   localparam int OVF_BIT         = 31;

   // Opcodes.
   localparam logic [FUNC_BITS-1:0] OP_ADD       = 4'd0;
   localparam logic [FUNC_BITS-1:0] OP_NEG       = 4'd1;
   localparam logic [FUNC_BITS-1:0] OP_MUL       = 4'd2;
   localparam logic [FUNC_BITS-1:0] OP_JUMP      = 4'd3;
   localparam logic [FUNC_BITS-1:0] OP_JUMP_ZERO = 4'd4;
   localparam logic [FUNC_BITS-1:0] OP_STORE_IMM = 4'd5;
   localparam logic [FUNC_BITS-1:0] OP_LESS_EQ   = 4'd6;
   localparam logic [FUNC_BITS-1:0] OP_HALT      = 4'd7;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_UNKNOWN  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_IGNORED  = 2'd3;

   // One instruction item.
   typedef struct packed {
      logic [FUNC_BITS-1:0]       func;
      logic [ADDR_FIELD_BITS-1:0] first_addr;
      logic [ADDR_FIELD_BITS-1:0] second_addr;
      logic [ADDR_FIELD_BITS-1:0] dest_addr;
      logic signed [IMM_BITS-1:0] immediate;
      logic [ADDR_FIELD_BITS-1:0] jump_target;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [PC_OUT_BITS-1:0]           next_pc;
      logic                             halted;
      logic [STATUS_BITS-1:0]           status;
      logic                             wrote;
      logic [ADDR_FIELD_BITS-1:0]       write_addr;
      logic signed [VALUE_OUT_BITS-1:0] write_value;
   } rsp_type;

   // Opcodes that write a data word.
   function automatic logic writes_word(input logic [FUNC_BITS-1:0] func);
      return func inside {OP_ADD, OP_NEG, OP_MUL, OP_STORE_IMM, OP_LESS_EQ};
   endfunction

   // Opcodes that read the first source word.
   function automatic logic uses_first(input logic [FUNC_BITS-1:0] func);
      return func inside {OP_ADD, OP_NEG, OP_MUL, OP_JUMP_ZERO, OP_LESS_EQ};
   endfunction

   // Opcodes that read the second source word.
   function automatic logic uses_second(input logic [FUNC_BITS-1:0] func);
      return func inside {OP_ADD, OP_MUL, OP_LESS_EQ};
   endfunction

   // Address field modulo the memory depth. The field is below 1024 and the
   // depth at least 16, so the quotient fits in six bits: six compare and
   // subtract steps of a restoring division finish the remainder.
   function automatic logic [ADDR_MAX_BITS-1:0] wrap_addr(
      input logic [ADDR_FIELD_BITS-1:0] addr,
      input int unsigned                depth
   );
      logic [ADDR_MAX_BITS+6:0] rem;
      logic [ADDR_MAX_BITS+6:0] step;
      rem = (ADDR_MAX_BITS+7)'(addr);
      for (int k = 5; k >= 0; k--) begin
         step = (ADDR_MAX_BITS+7)'(depth) << k;
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[ADDR_MAX_BITS-1:0];
   endfunction

endpackage

### src/mtm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_ram
// Generic synchronous RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mtm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/memory_to_memory_instruction_executor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_to_memory_instruction_executor_core
// Executes one instruction of a memory-to-memory machine per item.
// ----------------------------------------------------------------------------
// After reset the block zeroes its data memory in a pass over all MEM_DEPTH
// words (1024 by default) and holds req_stall high until that pass is done.
// It then takes one item per cycle unless the pipeline stalls; each item is
// read at the accepting edge, then executes, then retires, and its result is
// registered in the output register. Two copies of the data memory give the
// two read ports, and both are written by the retiring item. An item that
// reads a word written by the item directly ahead of it waits in the execute
// stage until that item retires; older writes reach it through a two-entry
// write history. Program counter and halt state are updated only at
// retirement, in item order.
// ----------------------------------------------------------------------------
module memory_to_memory_instruction_executor_core
   import mtm_pkg::*;
#(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW         = $clog2(MEM_DEPTH);
   localparam int PC_FULL    = $clog2(MEM_DEPTH + 1);
   localparam int PC_BITS    = (PC_FULL > ADDR_FIELD_BITS) ? PC_FULL : ADDR_FIELD_BITS;
   localparam int HIST_DEPTH = 2;

   // ---------------------------------------------------------------
   // Declarations
   // ---------------------------------------------------------------
   logic                        clear_ff;
   logic [AW-1:0]               clear_addr_ff;

   logic                        req_fire;
   logic [ADDR_MAX_BITS-1:0]    wrap_a;
   logic [ADDR_MAX_BITS-1:0]    wrap_b;
   logic [ADDR_MAX_BITS-1:0]    wrap_d;

   logic                        s1_valid_ff;
   logic [FUNC_BITS-1:0]        s1_func_ff;
   logic [AW-1:0]               s1_addr_a_ff;
   logic [AW-1:0]               s1_addr_b_ff;
   logic [AW-1:0]               s1_dest_ff;
   logic signed [IMM_BITS-1:0]  s1_imm_ff;
   logic [ADDR_FIELD_BITS-1:0]  s1_target_ff;

   logic [WORD_BITS-1:0]        ram_a_rdata;
   logic [WORD_BITS-1:0]        ram_b_rdata;
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [WORD_BITS-1:0]        ram_wdata;

   logic                        hist_valid_ff [HIST_DEPTH];
   logic [AW-1:0]               hist_addr_ff  [HIST_DEPTH];
   logic [WORD_BITS-1:0]        hist_data_ff  [HIST_DEPTH];

   logic signed [WORD_BITS-1:0] op_a;
   logic signed [WORD_BITS-1:0] op_b;
   logic [63:0]                 op_a_ext;
   logic [63:0]                 op_b_ext;
   logic signed [WORD_BITS-1:0] s1_simple;
   logic [63:0]                 s1_prod_lo;
   logic [31:0]                 s1_cross_a;
   logic [31:0]                 s1_cross_b;
   logic                        hazard;
   logic                        s1_move;
   logic                        s1_free;

   logic                        s2_valid_ff;
   logic [FUNC_BITS-1:0]        s2_func_ff;
   logic [AW-1:0]               s2_dest_ff;
   logic [ADDR_FIELD_BITS-1:0]  s2_target_ff;
   logic signed [WORD_BITS-1:0] s2_simple_ff;
   logic                        s2_zero_ff;
   logic [63:0]                 s2_prod_lo_ff;
   logic [31:0]                 s2_cross_a_ff;
   logic [31:0]                 s2_cross_b_ff;

   logic [63:0]                 s2_mul_full;
   logic signed [WORD_BITS-1:0] s2_value;
   logic signed [63:0]          s2_value_ext;
   logic                        s2_over;
   logic                        s2_ignored;
   logic                        s2_wrote;
   logic [STATUS_BITS-1:0]      s2_status;
   logic [PC_BITS-1:0]          s2_pc_step;
   logic                        s2_fire;
   logic                        s2_free;
   rsp_type                     s2_item;

   logic [PC_BITS-1:0]          pc_ff;
   logic [PC_BITS-1:0]          pc_in;
   logic                        stopped_ff;
   logic                        stopped_in;

   logic                        rsp_valid_ff;
   rsp_type                     rsp_data_ff;

   // ---------------------------------------------------------------
   // Memory clearing pass after reset
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         if (clear_addr_ff == AW'(MEM_DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end else begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Handshake and stage control
   // ---------------------------------------------------------------
   assign s2_fire   = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s2_free   = !s2_valid_ff || s2_fire;

   // The execute stage waits while the item ahead still has to write a word it reads.
   assign hazard    = s1_valid_ff && s2_valid_ff && writes_word(s2_func_ff) &&
                      ((uses_first(s1_func_ff) && (s2_dest_ff == s1_addr_a_ff)) ||
                       (uses_second(s1_func_ff) && (s2_dest_ff == s1_addr_b_ff)));
   assign s1_move   = s1_valid_ff && s2_free && !hazard;
   assign s1_free   = !s1_valid_ff || s1_move;
   assign req_stall = clear_ff || !s1_free;
   assign req_fire  = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // Read stage: wrap addresses and read both memory copies
   // ---------------------------------------------------------------
   assign wrap_a = wrap_addr(req_data.first_addr, MEM_DEPTH);
   assign wrap_b = wrap_addr(req_data.second_addr, MEM_DEPTH);
   assign wrap_d = wrap_addr(req_data.dest_addr, MEM_DEPTH);

   assign ram_we    = clear_ff || (s2_fire && s2_wrote);
   assign ram_waddr = clear_ff ? clear_addr_ff : s2_dest_ff;
   assign ram_wdata = clear_ff ? '0 : s2_value;

   mtm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_fire),
      .rd_addr (wrap_a[AW-1:0]),
      .rd_data (ram_a_rdata)
   );

   mtm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_fire),
      .rd_addr (wrap_b[AW-1:0]),
      .rd_data (ram_b_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff   <= req_data.func;
         s1_addr_a_ff <= wrap_a[AW-1:0];
         s1_addr_b_ff <= wrap_b[AW-1:0];
         s1_dest_ff   <= wrap_d[AW-1:0];
         s1_imm_ff    <= req_data.immediate;
         s1_target_ff <= req_data.jump_target;
      end
   end

   // ---------------------------------------------------------------
   // Write history: the last two words written, newest in entry zero
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff[0] <= 1'b0;
         hist_valid_ff[1] <= 1'b0;
      end else if (s2_fire && s2_wrote) begin
         hist_valid_ff[0] <= 1'b1;
         hist_valid_ff[1] <= hist_valid_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire && s2_wrote) begin
         hist_addr_ff[0] <= s2_dest_ff;
         hist_data_ff[0] <= s2_value;
         hist_addr_ff[1] <= hist_addr_ff[0];
         hist_data_ff[1] <= hist_data_ff[0];
      end
   end

   // ---------------------------------------------------------------
   // Execute stage: operand forwarding and arithmetic
   // ---------------------------------------------------------------
   always_comb begin
      op_a = ram_a_rdata;
      if (hist_valid_ff[1] && (hist_addr_ff[1] == s1_addr_a_ff)) begin
         op_a = hist_data_ff[1];
      end
      if (hist_valid_ff[0] && (hist_addr_ff[0] == s1_addr_a_ff)) begin
         op_a = hist_data_ff[0];
      end
      op_b = ram_b_rdata;
      if (hist_valid_ff[1] && (hist_addr_ff[1] == s1_addr_b_ff)) begin
         op_b = hist_data_ff[1];
      end
      if (hist_valid_ff[0] && (hist_addr_ff[0] == s1_addr_b_ff)) begin
         op_b = hist_data_ff[0];
      end
   end

   // Results of the simple operations (all but the multiply).
   always_comb begin
      case (s1_func_ff)
         OP_ADD:       s1_simple = op_a + op_b;
         OP_NEG:       s1_simple = -op_a;
         OP_STORE_IMM: s1_simple = WORD_BITS'(s1_imm_ff);
         OP_LESS_EQ:   s1_simple = WORD_BITS'(op_a <= op_b);
         default:      s1_simple = '0;
      endcase
   end

   // Low 64 bits of the product from three 32-bit partial products.
   assign op_a_ext   = 64'(op_a);
   assign op_b_ext   = 64'(op_b);
   assign s1_prod_lo = op_a_ext[31:0] * op_b_ext[31:0];
   assign s1_cross_a = op_a_ext[31:0] * op_b_ext[63:32];
   assign s1_cross_b = op_a_ext[63:32] * op_b_ext[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_fire) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_func_ff    <= s1_func_ff;
         s2_dest_ff    <= s1_dest_ff;
         s2_target_ff  <= s1_target_ff;
         s2_simple_ff  <= s1_simple;
         s2_zero_ff    <= (op_a == '0);
         s2_prod_lo_ff <= s1_prod_lo;
         s2_cross_a_ff <= s1_cross_a;
         s2_cross_b_ff <= s1_cross_b;
      end
   end

   // ---------------------------------------------------------------
   // Retire stage: final value, overflow and machine state
   // ---------------------------------------------------------------
   assign s2_mul_full  = {s2_prod_lo_ff[63:32] + s2_cross_a_ff + s2_cross_b_ff,
                          s2_prod_lo_ff[31:0]};
   assign s2_value     = (s2_func_ff == OP_MUL) ? s2_mul_full[WORD_BITS-1:0] : s2_simple_ff;
   assign s2_value_ext = 64'(s2_value);
   assign s2_over      = !s2_value_ext[63] && (s2_value_ext[62:OVF_BIT] != '0);
   assign s2_pc_step   = pc_ff + 1'b1;

   always_comb begin
      s2_ignored = stopped_ff || (pc_ff >= PC_BITS'(MEM_DEPTH));
      pc_in      = pc_ff;
      stopped_in = stopped_ff;
      s2_status  = ST_OK;
      s2_wrote   = 1'b0;
      if (s2_ignored) begin
         s2_status = ST_IGNORED;
      end else begin
         case (s2_func_ff)
            OP_ADD, OP_NEG, OP_MUL, OP_STORE_IMM, OP_LESS_EQ: begin
               s2_wrote = 1'b1;
            end
            OP_JUMP: begin
               pc_in = PC_BITS'(s2_target_ff);
            end
            OP_JUMP_ZERO: begin
               pc_in = s2_zero_ff ? PC_BITS'(s2_target_ff) : s2_pc_step;
            end
            OP_HALT: begin
               stopped_in = 1'b1;
            end
            default: begin
               s2_status = ST_UNKNOWN;
               pc_in     = s2_pc_step;
            end
         endcase
         // An add or multiply above the 32-bit limit still writes, then stops.
         if (s2_wrote) begin
            if (((s2_func_ff == OP_ADD) || (s2_func_ff == OP_MUL)) && s2_over) begin
               s2_status  = ST_OVERFLOW;
               stopped_in = 1'b1;
            end else begin
               pc_in = s2_pc_step;
            end
         end
      end
   end

   always_comb begin
      s2_item.next_pc     = PC_OUT_BITS'(pc_in);
      s2_item.halted      = stopped_in || (pc_in >= PC_BITS'(MEM_DEPTH));
      s2_item.status      = s2_status;
      s2_item.wrote       = s2_wrote;
      s2_item.write_addr  = s2_wrote ? ADDR_FIELD_BITS'(s2_dest_ff) : '0;
      s2_item.write_value = s2_wrote ? s2_value_ext : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= '0;
         stopped_ff <= 1'b0;
      end else if (s2_fire) begin
         pc_ff      <= pc_in;
         stopped_ff <= stopped_in;
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         rsp_data_ff <= s2_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------

   // No item retires while the memory is being cleared.
   a_no_retire_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !s2_fire)
      else $error("item retired during the memory clearing pass");

   // Once stopped, the machine stays stopped.
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stop flag cleared without reset");

   // An ignored item writes nothing and reports a stopped machine.
   a_ignored_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status == ST_IGNORED)) |->
         (!rsp_data_ff.wrote && rsp_data_ff.halted))
      else $error("ignored item shows a write or a running machine");

   // An overflow result always carries its write and a stopped machine.
   a_overflow_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status == ST_OVERFLOW)) |->
         (rsp_data_ff.wrote && rsp_data_ff.halted))
      else $error("overflow result without write or halt");

endmodule

### tb/memory_to_memory_instruction_executor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_to_memory_instruction_executor_core_tb
// Self-checking bench for the memory-to-memory instruction executor. A short
// table of directed instructions runs first, then random instructions that
// keep the machine running, and finally one stopping event (halt, overflow or
// a program counter that runs off the end) followed by items that must be
// ignored. Each result is checked against a typed row expectation or against
// an instruction-level machine model, under random idling on both channels.
// ----------------------------------------------------------------------------
module memory_to_memory_instruction_executor_core_tb;
   import mtm_pkg::*;

   localparam int                    DEPTH          = 1024;
   localparam logic [63:0]           INT32_MAX      = 64'd2147483647;
   localparam logic [FUNC_BITS-1:0]  OP_UNKNOWN_LO  = 4'd8;
   localparam logic [FUNC_BITS-1:0]  OP_UNKNOWN_HI  = 4'd15;
   localparam int                    NUM_DIRECTED   = 20;
   localparam int                    NUM_RANDOM     = 500;
   localparam int                    NUM_IGNORED    = 12;
   localparam int                    QUIET_TAIL_LEN = 60;

   typedef enum int {STOP_BY_HALT, STOP_BY_OVERFLOW, STOP_BY_PC_END} stop_kind_type;

   typedef struct {
      req_type instr;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   // Ports of the block.
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_data;

   // Machine model: data memory, program counter and stop flag.
   logic [63:0] mem_words [0:DEPTH-1];
   logic [10:0] pc_reg;
   bit          stop_flag;

   // Results still to arrive, oldest first.
   rsp_type     pending_results [$];

   // Typed expectation that travels with the item on the request port.
   bit          drv_typed  = 1'b0;
   rsp_type     drv_want   = '0;

   int          fail_cnt   = 0;
   logic [31:0] cyc        = '0;
   bit          quiet_tail = 1'b0;
   int          stall_left = 0;
   wire         idle_ok    = (cyc[6:5] != 2'b00) && !quiet_tail;

   memory_to_memory_instruction_executor_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Executes one instruction on the model. With commit low it only looks
   // ahead and leaves the model untouched.
   function automatic rsp_type run_instr(input req_type it, input bit commit);
      logic [63:0] wa;
      logic [63:0] wb;
      logic [63:0] v;
      logic [10:0] pc;
      bit          stop;
      bit          wr;
      logic [1:0]  st;
      rsp_type     r;
      wa   = mem_words[it.first_addr];
      wb   = mem_words[it.second_addr];
      v    = '0;
      pc   = pc_reg;
      stop = stop_flag;
      wr   = 1'b0;
      st   = ST_OK;
      if (stop || pc >= DEPTH) begin
         st = ST_IGNORED;
      end else begin
         case (it.func)
            OP_ADD: begin
               v  = wa + wb;
               wr = 1'b1;
            end
            OP_NEG: begin
               v  = 64'd0 - wa;
               wr = 1'b1;
            end
            OP_MUL: begin
               v  = wa * wb;
               wr = 1'b1;
            end
            OP_JUMP: begin
               pc = {1'b0, it.jump_target};
            end
            OP_JUMP_ZERO: begin
               pc = (wa == 64'd0) ? {1'b0, it.jump_target} : pc + 11'd1;
            end
            OP_STORE_IMM: begin
               v  = {{32{it.immediate[31]}}, it.immediate};
               wr = 1'b1;
            end
            OP_LESS_EQ: begin
               v  = ($signed(wa) <= $signed(wb)) ? 64'd1 : 64'd0;
               wr = 1'b1;
            end
            OP_HALT: begin
               stop = 1'b1;
            end
            default: begin
               st = ST_UNKNOWN;
               pc = pc + 11'd1;
            end
         endcase
         // A positive add or multiply result beyond the 32-bit range is still
         // written, but it stops the machine without advancing the counter.
         if (wr) begin
            if ((it.func == OP_ADD || it.func == OP_MUL) && !v[63] && v > INT32_MAX) begin
               st   = ST_OVERFLOW;
               stop = 1'b1;
            end else begin
               pc = pc + 11'd1;
            end
         end
      end
      if (commit) begin
         if (wr) begin
            mem_words[it.dest_addr] = v;
         end
         pc_reg    = pc;
         stop_flag = stop;
      end
      r.next_pc     = pc;
      r.halted      = stop || (pc >= DEPTH);
      r.status      = st;
      r.wrote       = wr;
      r.write_addr  = wr ? it.dest_addr : '0;
      r.write_value = wr ? v : '0;
      return r;
   endfunction

   function automatic req_type mk_instr(
      input logic [FUNC_BITS-1:0] f,
      input int                   a1,
      input int                   a2,
      input int                   d,
      input int                   imm,
      input int                   tgt
   );
      req_type it;
      it.func        = f;
      it.first_addr  = ADDR_FIELD_BITS'(a1);
      it.second_addr = ADDR_FIELD_BITS'(a2);
      it.dest_addr   = ADDR_FIELD_BITS'(d);
      it.immediate   = IMM_BITS'(imm);
      it.jump_target = ADDR_FIELD_BITS'(tgt);
      return it;
   endfunction

   function automatic rsp_type mk_result(
      input int                     pc,
      input int                     halted,
      input logic [STATUS_BITS-1:0] st,
      input int                     wr,
      input int                     addr,
      input logic [63:0]            value
   );
      rsp_type r;
      r.next_pc     = PC_OUT_BITS'(pc);
      r.halted      = (halted != 0);
      r.status      = st;
      r.wrote       = (wr != 0);
      r.write_addr  = ADDR_FIELD_BITS'(addr);
      r.write_value = value;
      return r;
   endfunction

   // Mostly a handful of low words so that data gets reused, sometimes any word.
   function automatic logic [ADDR_FIELD_BITS-1:0] pick_addr();
      if ($urandom_range(0, 3) == 0) begin
         return ADDR_FIELD_BITS'($urandom_range(0, DEPTH - 1));
      end
      return ADDR_FIELD_BITS'($urandom_range(0, 15));
   endfunction

   function automatic req_type rand_instr();
      req_type it;
      if ($urandom_range(0, 9) != 0) begin
         it.func = FUNC_BITS'($urandom_range(0, 6));
      end else begin
         it.func = FUNC_BITS'($urandom_range(0, 15));
      end
      it.first_addr  = pick_addr();
      it.second_addr = pick_addr();
      it.dest_addr   = pick_addr();
      case ($urandom_range(0, 3))
         0:       it.immediate = '0;
         1:       it.immediate = IMM_BITS'($urandom_range(0, 200)) - 32'sd100;
         default: it.immediate = $urandom();
      endcase
      if ($urandom_range(0, 7) == 0) begin
         it.jump_target = ADDR_FIELD_BITS'(DEPTH - 1);
      end else begin
         it.jump_target = ADDR_FIELD_BITS'($urandom_range(0, DEPTH - 1));
      end
      return it;
   endfunction

   // Drives one item from a falling edge until it is taken, and returns at
   // the next falling edge.
   task automatic send_item(input req_type it, input bit typed, input rsp_type want);
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_data  = it;
      drv_typed = typed;
      drv_want  = want;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Holds the request side off until every result has come back.
   task automatic drain();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Receiver idling in short random bursts.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  = 1'b1;
         stall_left = stall_left - 1;
      end else if (idle_ok && $urandom_range(0, 4) == 0) begin
         rsp_stall  = 1'b1;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Model update on every accepted item and check of every accepted result.
   always @(posedge clock) begin
      rsp_type pred;
      rsp_type want;
      cyc <= cyc + 32'd1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pred = run_instr(req_data, 1'b1);
            pending_results.push_back(drv_typed ? drv_want : pred);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               fail_cnt = fail_cnt + 1;
               if (fail_cnt <= 10) begin
                  $display("unexpected result at cycle %0d", cyc);
               end
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.next_pc !== want.next_pc || rsp_data.halted !== want.halted ||
                   rsp_data.status !== want.status || rsp_data.wrote !== want.wrote ||
                   rsp_data.write_addr !== want.write_addr ||
                   rsp_data.write_value !== want.write_value) begin
                  fail_cnt = fail_cnt + 1;
                  if (fail_cnt <= 10) begin
                     $display({"mismatch at cycle %0d (expected/actual): pc %0d/%0d ",
                               "halted %0b/%0b status %0d/%0d wrote %0b/%0b ",
                               "addr %0d/%0d value %0d/%0d"},
                              cyc, want.next_pc, rsp_data.next_pc, want.halted,
                              rsp_data.halted, want.status, rsp_data.status, want.wrote,
                              rsp_data.wrote, want.write_addr, rsp_data.write_addr,
                              want.write_value, rsp_data.write_value);
                  end
               end
            end
         end
      end
   end

   // Main stimulus sequence.
   initial begin
      dir_row_type   dir_rows [NUM_DIRECTED];
      req_type       it;
      rsp_type       peek;
      stop_kind_type stop_kind;
      for (int i = 0; i < DEPTH; i++) begin
         mem_words[i] = '0;
      end
      pc_reg    = '0;
      stop_flag = 1'b0;

      // Directed instructions; memory is all zero when they start.
      dir_rows[0]  = '{mk_instr(OP_ADD, 0, 1023, 0, 0, 0), 1'b1,
                       mk_result(1, 0, ST_OK, 1, 0, 64'd0)};
      dir_rows[1]  = '{mk_instr(OP_STORE_IMM, 0, 0, 1023, 32'sh7FFFFFFF, 0), 1'b1,
                       mk_result(2, 0, ST_OK, 1, 1023, 64'd2147483647)};
      dir_rows[2]  = '{mk_instr(OP_STORE_IMM, 0, 0, 1, 32'sh80000000, 0), 1'b1,
                       mk_result(3, 0, ST_OK, 1, 1, 64'hFFFFFFFF80000000)};
      dir_rows[3]  = '{mk_instr(OP_NEG, 1, 0, 2, 0, 0), 1'b1,
                       mk_result(4, 0, ST_OK, 1, 2, 64'd2147483648)};
      dir_rows[4]  = '{mk_instr(OP_ADD, 1023, 1, 3, 0, 0), 1'b0, '0};
      // Product of the two 32-bit extremes, then sums that reach and wrap 64 bits.
      dir_rows[5]  = '{mk_instr(OP_MUL, 1, 2, 4, 0, 0), 1'b0, '0};
      dir_rows[6]  = '{mk_instr(OP_ADD, 4, 4, 5, 0, 0), 1'b0, '0};
      dir_rows[7]  = '{mk_instr(OP_ADD, 5, 5, 6, 0, 0), 1'b0, '0};
      dir_rows[8]  = '{mk_instr(OP_NEG, 5, 0, 7, 0, 0), 1'b0, '0};
      dir_rows[9]  = '{mk_instr(OP_LESS_EQ, 5, 1023, 8, 0, 0), 1'b0, '0};
      dir_rows[10] = '{mk_instr(OP_LESS_EQ, 1023, 5, 9, 0, 0), 1'b0, '0};
      dir_rows[11] = '{mk_instr(OP_LESS_EQ, 3, 3, 10, 0, 0), 1'b0, '0};
      dir_rows[12] = '{mk_instr(OP_JUMP, 0, 0, 0, 0, 1023), 1'b1,
                       mk_result(1023, 0, ST_OK, 0, 0, 64'd0)};
      // Jump-if-zero taken on a zero word, then not taken on a nonzero one.
      dir_rows[13] = '{mk_instr(OP_JUMP_ZERO, 6, 0, 0, 0, 0), 1'b0, '0};
      dir_rows[14] = '{mk_instr(OP_JUMP_ZERO, 3, 0, 0, 0, 500), 1'b0, '0};
      dir_rows[15] = '{mk_instr(OP_UNKNOWN_LO, 0, 0, 0, 0, 0), 1'b0, '0};
      dir_rows[16] = '{mk_instr(OP_UNKNOWN_HI, 1023, 1023, 1023, -1, 1023), 1'b0, '0};
      dir_rows[17] = '{mk_instr(OP_MUL, 3, 3, 11, 0, 0), 1'b0, '0};
      // Largest 32-bit value exactly: no overflow.
      dir_rows[18] = '{mk_instr(OP_ADD, 1023, 6, 12, 0, 0), 1'b0, '0};
      dir_rows[19] = '{mk_instr(OP_NEG, 6, 0, 13, 0, 0), 1'b0, '0};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_item(dir_rows[i].instr, dir_rows[i].typed, dir_rows[i].want);
      end

      // Random instructions. Anything that would stop the machine is turned
      // into a store, or into a jump when the counter sits on the last word.
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM / 2) begin
            drain();
         end
         if (i == NUM_RANDOM - QUIET_TAIL_LEN) begin
            quiet_tail = 1'b1;
         end
         it   = rand_instr();
         peek = run_instr(it, 1'b0);
         if (peek.halted) begin
            it.func = (pc_reg == 11'(DEPTH - 1)) ? OP_JUMP : OP_STORE_IMM;
         end
         send_item(it, 1'b0, '0);
      end

      // One way of stopping the machine, chosen per run.
      drain();
      stop_kind = stop_kind_type'($urandom_range(0, 2));
      case (stop_kind)
         STOP_BY_HALT: begin
            send_item(mk_instr(OP_HALT, 0, 0, 0, 0, 0), 1'b0, '0);
         end
         STOP_BY_OVERFLOW: begin
            send_item(mk_instr(OP_STORE_IMM, 0, 0, 20, 32'sh7FFFFFFF, 0), 1'b0, '0);
            send_item(mk_instr(OP_ADD, 20, 20, 21, 0, 0), 1'b0, '0);
         end
         default: begin
            send_item(mk_instr(OP_JUMP, 0, 0, 0, 0, 1023), 1'b0, '0);
            send_item(mk_instr(OP_STORE_IMM, 0, 0, 0, 0, 0), 1'b0, '0);
         end
      endcase

      // Everything after the stop must be ignored.
      for (int i = 0; i < NUM_IGNORED; i++) begin
         it      = rand_instr();
         it.func = FUNC_BITS'($urandom_range(0, 15));
         send_item(it, 1'b0, '0);
      end

      drain();
      repeat (20) @(negedge clock);
      if (pending_results.size() != 0) begin
         fail_cnt = fail_cnt + 1;
         $display("results missing: %0d", pending_results.size());
      end
      if (fail_cnt == 0) begin
         $display("[memory_to_memory_instruction_executor_core] OK");
      end else begin
         $display("[memory_to_memory_instruction_executor_core] ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("[memory_to_memory_instruction_executor_core] ERROR");
      $finish;
   end

endmodule
